// ===== hw/rtl/narp_pkg.sv =====
// shared types and constants for the notification attribute request parser
// no dependencies
package narp_pkg;

  // longest message; bytes_left above this is clamped
  localparam logic [12:0] MAX_MESSAGE_BYTES = 13'd4096;

  localparam logic [12:0] MIN_MSG_BYTES   = 13'd7;
  localparam logic [12:0] MIN_TOKEN_BYTES = 13'd3;
  localparam logic [7:0]  CMD_ACTION      = 8'd128;
  localparam logic [7:0]  ATTR_LEN_BYTE   = 8'd127;
  localparam logic [7:0]  ATTR_ID_A       = 8'd0;
  localparam logic [7:0]  ATTR_ID_B       = 8'd4;
  localparam logic [7:0]  ATTR_ID_C       = 8'd5;
  localparam logic [15:0] FIXED_MAX_LEN   = 16'd128;
  localparam logic [2:0]  HDR_LAST_IDX    = 3'd4;
  localparam logic [1:0]  SKIP_BYTES      = 2'd2;

  // record kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_ACTION = 3'd1;
  localparam logic [2:0] KIND_ATTR   = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_HEADER = 8'b0000_0010,
    PH_ACTION = 8'b0000_0100,
    PH_TOKEN  = 8'b0000_1000,
    PH_LEN    = 8'b0001_0000,
    PH_LENHI  = 8'b0010_0000,
    PH_SKIP   = 8'b0100_0000,
    PH_DRAIN  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t       phase;
    logic [2:0]   hdr_idx;
    logic [7:0]   cmd;
    logic [31:0]  id_acc;
    logic [7:0]   pend_attr;
    logic [7:0]   len_lo;
    logic [1:0]   skip_cnt;
    logic         short_err;
  } parse_st_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         cmd;
    logic signed [31:0] nid;
    logic [7:0]         act;
    logic [7:0]         aid;
    logic [15:0]        mlen;
    logic               done;
  } record_t;

endpackage

// ===== hw/rtl/notification_attr_request_parser_top.sv =====
// top level of the notification attribute request parser
// depends on narp_pkg and narp_step
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte,        | byte beats in
//          | in_bytes_left                           |
//  out     | out_valid, out_stall, out_record_kind,   | record beats out
//          | out_command, out_notification_id,        |
//          | out_action_id, out_attribute_id,         |
//          | out_max_length, out_done_res             |
//
// one byte beat per cycle sustained while out_stall is low; each byte
// waits in the input register and its record, if any, is loaded into the
// output register when the byte is parsed, which also raises out_valid
// rst_n is synchronous, active low; it empties both registers and puts
// the parser back to waiting for the first byte of a message
// out_stall holds the output register; the input register then holds
// and in_stall rises only while that input register is full and blocked
module notification_attr_request_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic [12:0]        in_bytes_left,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_record_kind,
  output logic [7:0]         out_command,
  output logic signed [31:0] out_notification_id,
  output logic [7:0]         out_action_id,
  output logic [7:0]         out_attribute_id,
  output logic [15:0]        out_max_length,
  output logic               out_done_res
);
  import narp_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [12:0] s1_bl_r;

  // parser state and output register
  parse_st_t   st_r;
  parse_st_t   st_nxt;
  logic        out_valid_r;
  record_t     out_rec_r;

  logic        step_emit;
  record_t     step_rec;
  logic        proc;      // byte in the input register is parsed this cycle
  logic        s1_last;

  // the output slot is free when empty or being drained this cycle
  assign proc     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !proc;
  assign s1_last  = (s1_bl_r <= 13'd1);

  narp_step u_step (
    .st_i         (st_r),
    .data_byte_i  (s1_byte_r),
    .bytes_left_i (s1_bl_r),
    .st_nxt       (st_nxt),
    .emit_o       (step_emit),
    .rec_o        (step_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  // byte payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_bl_r   <= in_bytes_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= step_emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && step_emit) begin
      out_rec_r <= step_rec;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = out_rec_r.kind;
  assign out_command         = out_rec_r.cmd;
  assign out_notification_id = out_rec_r.nid;
  assign out_action_id       = out_rec_r.act;
  assign out_attribute_id    = out_rec_r.aid;
  assign out_max_length      = out_rec_r.mlen;
  assign out_done_res        = out_rec_r.done;

  // the last byte of a message always leaves the parser waiting for a new one
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last |=> st_r.phase == PH_IDLE)
    else $error("parser not idle after last byte");

  // the last byte always yields a record
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_last |=> out_valid_r && out_rec_r.done)
    else $error("last byte gave no done record");

  // header byte counter stays within the four id bytes
  a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_HEADER |-> st_r.hdr_idx >= 3'd1 && st_r.hdr_idx <= HDR_LAST_IDX)
    else $error("header index out of range");

  // a too-short error is only ever the final record
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r.kind == KIND_ERROR |-> out_rec_r.done)
    else $error("error record without done");

endmodule

// ===== hw/rtl/narp_step.sv =====
// one parse step: next parser state and the record due for one byte
// depends on narp_pkg
module narp_step (
  input  narp_pkg::parse_st_t st_i,
  input  logic [7:0]          data_byte_i,
  input  logic [12:0]         bytes_left_i,
  output narp_pkg::parse_st_t st_nxt,
  output logic                emit_o,
  output narp_pkg::record_t   rec_o
);
  import narp_pkg::*;

  logic [12:0] bl_c;
  logic        last;
  logic [4:0]  lane_sh;
  logic [31:0] id_merged;
  logic        emit;
  record_t     rec;
  parse_st_t   st;
  logic [1:0]  skip_dec;

  always_comb begin
    bl_c      = (bytes_left_i > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : bytes_left_i;
    last      = (bl_c <= 13'd1);
    lane_sh   = {st_i.hdr_idx[1:0] - 2'd1, 3'b000};
    id_merged = st_i.id_acc | ({24'd0, data_byte_i} << lane_sh);
    skip_dec  = st_i.skip_cnt - 2'd1;

    st   = st_i;
    emit = 1'b0;
    rec  = '0;

    unique case (st_i.phase)
      PH_IDLE: begin
        st.id_acc = '0;
        if (bl_c < MIN_MSG_BYTES) begin
          st.cmd       = '0;
          st.short_err = 1'b1;
          st.phase     = PH_DRAIN;
        end else begin
          st.cmd     = data_byte_i;
          st.hdr_idx = 3'd1;
          st.phase   = PH_HEADER;
        end
      end
      PH_HEADER: begin
        st.id_acc = id_merged;
        if (st_i.hdr_idx >= HDR_LAST_IDX) begin
          emit        = 1'b1;
          rec.kind    = KIND_HEADER;
          rec.cmd     = st_i.cmd;
          rec.nid     = id_merged;
          st.hdr_idx  = '0;
          st.phase    = (st_i.cmd == CMD_ACTION) ? PH_ACTION : PH_TOKEN;
        end else begin
          st.hdr_idx = st_i.hdr_idx + 3'd1;
        end
      end
      PH_ACTION: begin
        emit     = 1'b1;
        rec.kind = KIND_ACTION;
        rec.act  = data_byte_i;
        st.phase = PH_DRAIN;
      end
      PH_TOKEN: begin
        if (bl_c < MIN_TOKEN_BYTES) begin
          st.phase = PH_DRAIN;
        end else if (data_byte_i == ATTR_ID_A || data_byte_i == ATTR_ID_B ||
                     data_byte_i == ATTR_ID_C) begin
          emit     = 1'b1;
          rec.kind = KIND_ATTR;
          rec.aid  = data_byte_i;
          rec.mlen = FIXED_MAX_LEN;
        end else begin
          st.pend_attr = data_byte_i;
          st.phase     = PH_LEN;
        end
      end
      PH_LEN: begin
        if (st_i.pend_attr == ATTR_LEN_BYTE) begin
          emit        = 1'b1;
          rec.kind    = KIND_ATTR;
          rec.aid     = ATTR_LEN_BYTE;
          rec.mlen    = {8'd0, data_byte_i};
          st.skip_cnt = SKIP_BYTES;
          st.phase    = PH_SKIP;
        end else begin
          st.len_lo = data_byte_i;
          st.phase  = PH_LENHI;
        end
      end
      PH_LENHI: begin
        emit     = 1'b1;
        rec.kind = KIND_ATTR;
        rec.aid  = st_i.pend_attr;
        rec.mlen = {data_byte_i, st_i.len_lo};
        st.phase = PH_TOKEN;
      end
      PH_SKIP: begin
        st.skip_cnt = skip_dec;
        if (skip_dec == 2'd0) begin
          st.phase = PH_TOKEN;
        end
      end
      PH_DRAIN: begin
        st = st_i;
      end
      default: begin
        st = st_i;
      end
    endcase

    // last byte closes the message whatever the phase
    // a one-byte short message sets the error flag on this same byte
    if (last) begin
      if (!emit) begin
        emit     = 1'b1;
        rec      = '0;
        rec.kind = st.short_err ? KIND_ERROR : KIND_END;
      end
      st       = '0;
      st.phase = PH_IDLE;
    end
    rec.done = last;

    st_nxt = st;
    emit_o = emit;
    rec_o  = rec;
  end

endmodule
